/* hw/rtl/wfac_pkg.sv */
`timescale 1ns / 1ps
// Package for the worst-fit allocator: sizes, record types, codes.
// Used by the cell, ring and top-level modules; depends on nothing.
package wfac_pkg;

  // Free-segment ring: one cell per possible free segment
  localparam int SEG_CELLS = 4097;
  localparam int PASS_W    = 13;
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(SEG_CELLS - 1);

  // Request bookkeeping memory
  localparam int RQ_DEPTH = 4096;
  localparam int RQ_AW    = 12;
  localparam logic [12:0] MAX_REQ   = 13'd4096;
  localparam logic [16:0] MAX_CELLS = 17'd65536;

  typedef struct packed {
    logic        action;
    logic [16:0] block_size;
    logic [12:0] request_number;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [16:0] start_address;
  } out_item_t;

  // One free segment [seg_lo, seg_hi)
  typedef struct packed {
    logic        valid;
    logic [16:0] seg_lo;
    logic [16:0] seg_hi;
  } seg_t;

  typedef enum logic [1:0] {
    RQ_DECLINED = 2'd0,
    RQ_ALLOC    = 2'd1,
    RQ_FREED    = 2'd2
  } rq_state_t;

  typedef struct packed {
    rq_state_t   outcome;
    logic [16:0] blk_lo;
    logic [16:0] blk_hi;
  } rq_t;

  localparam int RQ_W = $bits(rq_t);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN1,
    ST_DECIDE,
    ST_FWR,
    ST_FRD,
    ST_FCHK,
    ST_SCAN2
  } state_t;

endpackage

/* hw/rtl/wfac_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module wfac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or registered read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/wfac_cell.sv */
`timescale 1ns / 1ps
// One ring cell: holds a free-segment record and passes it on.
// Depends on wfac_pkg.
module wfac_cell (
  input  logic          clk,
  input  logic          en,
  input  wfac_pkg::seg_t d,
  output wfac_pkg::seg_t q
);

  wfac_pkg::seg_t seg_r;

  // shift one position per enabled cycle; contents set by the clearing pass
  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= d;
    end
  end

  assign q = seg_r;

endmodule

/* hw/rtl/wfac_ring.sv */
`timescale 1ns / 1ps
// Chain of segment cells; the top level closes the loop through its head logic.
// Depends on wfac_pkg and wfac_cell.
module wfac_ring (
  input  logic          clk,
  input  logic          en,
  input  wfac_pkg::seg_t head_in,
  output wfac_pkg::seg_t tail_out
);

  wfac_pkg::seg_t link [wfac_pkg::SEG_CELLS+1];

  assign link[0] = head_in;

  // row of identical cells, each feeding its neighbor
  for (genvar i = 0; i < wfac_pkg::SEG_CELLS; i++) begin : g_cell
    wfac_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (link[i]),
      .q   (link[i+1])
    );
  end

  assign tail_out = link[wfac_pkg::SEG_CELLS];

endmodule

/* hw/rtl/worst_fit_allocator_coalescing.sv */
`timescale 1ns / 1ps
// Worst-fit allocator with coalescing: top level, sequencer and head logic.
// Depends on wfac_pkg, wfac_ring, wfac_ram.
//
// Usage:
//   in_valid/in_stall/in_data carry requests (allocate or free). One request
//   is worked on at a time; in_stall stays high while one is in progress.
//   out_valid/out_stall/out_data carry one result per allocate, none per free.
//   Free segments circulate in a ring of 4097 cells; each pass moves every
//   segment once through the head stage. An allocate takes one pass to find
//   the largest free segment and, when granted, a second to shrink it. A valid
//   free takes two passes (find neighbors, then merge); a bad free takes none.
//   A request past capacity is answered or dropped without a pass.
//   The rate is set by the ring pass length, one cell per cycle.
//   After reset and after each cfg_we write, a clearing pass rebuilds one
//   free segment; no request is taken meanwhile.
//   The result sits in an output register; while out_stall is high it holds
//   and a following allocate waits before its result is loaded.
module worst_fit_allocator_coalescing (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wfac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wfac_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);

  wfac_pkg::state_t state_r, state_nxt;
  logic [wfac_pkg::PASS_W-1:0] pass_r, pass_nxt;
  logic [12:0] req_cnt_r, req_cnt_nxt;
  logic [12:0] idx_r, idx_nxt;
  logic [16:0] total_r, total_nxt;
  wfac_pkg::in_item_t item_r, item_nxt;
  logic full_r, full_nxt;
  logic best_v_r, best_v_nxt;
  logic [16:0] best_lo_r, best_lo_nxt, best_hi_r, best_hi_nxt;
  logic pf_r, pf_nxt, nf_r, nf_nxt;
  logic [16:0] plo_r, plo_nxt, nhi_r, nhi_nxt;
  logic [16:0] blk_lo_r, blk_lo_nxt, blk_hi_r, blk_hi_nxt;
  logic placed_r, placed_nxt;
  logic out_valid_r, out_valid_nxt;
  wfac_pkg::out_item_t out_data_r, out_data_nxt;

  wfac_pkg::seg_t tail, head;
  logic ring_en;
  logic ram_we;
  logic [wfac_pkg::RQ_AW-1:0] ram_addr;
  wfac_pkg::rq_t ram_wdata, ram_rdata;

  logic [16:0] tail_size, best_size, cfg_clamped, merged_lo, merged_hi, shrunk_lo;
  logic [12:0] rnum_m1;
  logic pass_end, grant, is_prev, is_next, out_free;

  wfac_ring u_ring (
    .clk      (clk),
    .en       (ring_en),
    .head_in  (head),
    .tail_out (tail)
  );

  wfac_ram #(
    .WIDTH (wfac_pkg::RQ_W),
    .DEPTH (wfac_pkg::RQ_DEPTH)
  ) u_rq_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared comparisons and sums on the segment leaving the ring and the current request
  assign tail_size = tail.seg_hi - tail.seg_lo;
  assign best_size = best_hi_r - best_lo_r;
  assign pass_end  = (pass_r == wfac_pkg::PASS_LAST);
  assign is_prev   = tail.valid && (tail.seg_hi == blk_lo_r);
  assign is_next   = tail.valid && (tail.seg_lo == blk_hi_r);
  assign merged_lo = pf_r ? plo_r : blk_lo_r;
  assign merged_hi = nf_r ? nhi_r : blk_hi_r;
  assign shrunk_lo = tail.seg_lo + item_r.block_size;
  assign rnum_m1   = item_r.request_number - 13'd1;
  assign out_free  = !out_valid_r || !out_stall;
  assign grant     = !full_r && best_v_r && (item_r.block_size != 17'd0) &&
                     (item_r.block_size <= best_size);

  // clamp the size register into range
  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata == 17'd0) begin
      cfg_clamped = 17'd1;
    end else if (cfg_wdata > wfac_pkg::MAX_CELLS) begin
      cfg_clamped = wfac_pkg::MAX_CELLS;
    end
  end

  // head stage: what re-enters the ring in each pass
  always_comb begin
    head = tail;
    case (state_r)
      wfac_pkg::ST_INIT: begin
        head.valid  = (pass_r == '0);
        head.seg_lo = 17'd0;
        head.seg_hi = total_r;
      end
      wfac_pkg::ST_SCAN2: begin
        if (item_r.action == wfac_pkg::ACT_ALLOC) begin
          if (tail.valid && (tail.seg_lo == best_lo_r)) begin
            head.seg_lo = shrunk_lo;
            head.valid  = (shrunk_lo != tail.seg_hi);
          end
        end else if (is_prev) begin
          head.seg_lo = merged_lo;
          head.seg_hi = merged_hi;
        end else if (is_next) begin
          head.valid  = !pf_r;
          head.seg_lo = merged_lo;
          head.seg_hi = merged_hi;
        end else if (!pf_r && !nf_r && !tail.valid && !placed_r) begin
          head.valid  = 1'b1;
          head.seg_lo = merged_lo;
          head.seg_hi = merged_hi;
        end
      end
      default: begin
        head = tail;
      end
    endcase
  end

  // sequencer: next state, bookkeeping and memory port
  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    req_cnt_nxt   = req_cnt_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    item_nxt      = item_r;
    full_nxt      = full_r;
    best_v_nxt    = best_v_r;
    best_lo_nxt   = best_lo_r;
    best_hi_nxt   = best_hi_r;
    pf_nxt        = pf_r;
    nf_nxt        = nf_r;
    plo_nxt       = plo_r;
    nhi_nxt       = nhi_r;
    blk_lo_nxt    = blk_lo_r;
    blk_hi_nxt    = blk_hi_r;
    placed_nxt    = placed_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ring_en       = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = idx_r[wfac_pkg::RQ_AW-1:0];
    ram_wdata     = '{outcome: wfac_pkg::RQ_FREED, blk_lo: '0, blk_hi: '0};

    case (state_r)
      wfac_pkg::ST_INIT: begin
        ring_en  = 1'b1;
        pass_nxt = pass_r + 1'b1;
        if (pass_end) begin
          state_nxt = wfac_pkg::ST_IDLE;
        end
      end
      wfac_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          full_nxt   = (req_cnt_r >= wfac_pkg::MAX_REQ);
          idx_nxt    = req_cnt_r;
          pass_nxt   = '0;
          best_v_nxt = 1'b0;
          pf_nxt     = 1'b0;
          nf_nxt     = 1'b0;
          if (req_cnt_r < wfac_pkg::MAX_REQ) begin
            req_cnt_nxt = req_cnt_r + 13'd1;
          end
          if (in_data.action == wfac_pkg::ACT_ALLOC) begin
            state_nxt = (req_cnt_r >= wfac_pkg::MAX_REQ) ?
                        wfac_pkg::ST_DECIDE : wfac_pkg::ST_SCAN1;
          end else if (req_cnt_r < wfac_pkg::MAX_REQ) begin
            state_nxt = wfac_pkg::ST_FWR;
          end
        end
      end
      wfac_pkg::ST_SCAN1: begin
        ring_en  = 1'b1;
        pass_nxt = pass_r + 1'b1;
        if (item_r.action == wfac_pkg::ACT_ALLOC) begin
          // largest segment, lower address on ties
          if (tail.valid && (!best_v_r || (tail_size > best_size) ||
              ((tail_size == best_size) && (tail.seg_lo < best_lo_r)))) begin
            best_v_nxt  = 1'b1;
            best_lo_nxt = tail.seg_lo;
            best_hi_nxt = tail.seg_hi;
          end
        end else begin
          if (is_prev) begin
            pf_nxt  = 1'b1;
            plo_nxt = tail.seg_lo;
          end
          if (is_next) begin
            nf_nxt  = 1'b1;
            nhi_nxt = tail.seg_hi;
          end
        end
        if (pass_end) begin
          pass_nxt   = '0;
          placed_nxt = 1'b0;
          state_nxt  = (item_r.action == wfac_pkg::ACT_ALLOC) ?
                       wfac_pkg::ST_DECIDE : wfac_pkg::ST_SCAN2;
        end
      end
      wfac_pkg::ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.granted       = grant;
          out_data_nxt.start_address = grant ? (best_lo_r + 17'd1) : 17'd0;
          ram_we                     = !full_r;
          ram_wdata.outcome          = grant ? wfac_pkg::RQ_ALLOC : wfac_pkg::RQ_DECLINED;
          ram_wdata.blk_lo           = best_lo_r;
          ram_wdata.blk_hi           = best_lo_r + item_r.block_size;
          state_nxt                  = grant ? wfac_pkg::ST_SCAN2 : wfac_pkg::ST_IDLE;
        end
      end
      wfac_pkg::ST_FWR: begin
        // the free request itself is recorded as freed
        ram_we = 1'b1;
        if ((item_r.request_number != 13'd0) && (item_r.request_number <= idx_r)) begin
          state_nxt = wfac_pkg::ST_FRD;
        end else begin
          state_nxt = wfac_pkg::ST_IDLE;
        end
      end
      wfac_pkg::ST_FRD: begin
        ram_addr  = rnum_m1[wfac_pkg::RQ_AW-1:0];
        state_nxt = wfac_pkg::ST_FCHK;
      end
      wfac_pkg::ST_FCHK: begin
        ram_addr = rnum_m1[wfac_pkg::RQ_AW-1:0];
        if (ram_rdata.outcome == wfac_pkg::RQ_ALLOC) begin
          ram_we           = 1'b1;
          ram_wdata.blk_lo = ram_rdata.blk_lo;
          ram_wdata.blk_hi = ram_rdata.blk_hi;
          blk_lo_nxt       = ram_rdata.blk_lo;
          blk_hi_nxt       = ram_rdata.blk_hi;
          state_nxt        = wfac_pkg::ST_SCAN1;
        end else begin
          state_nxt = wfac_pkg::ST_IDLE;
        end
      end
      wfac_pkg::ST_SCAN2: begin
        ring_en  = 1'b1;
        pass_nxt = pass_r + 1'b1;
        if ((item_r.action == wfac_pkg::ACT_FREE) && !pf_r && !nf_r && !tail.valid) begin
          placed_nxt = 1'b1;
        end
        if (pass_end) begin
          state_nxt = wfac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wfac_pkg::ST_INIT;
      end
    endcase

    // register write restarts the whole block
    if (cfg_we) begin
      total_nxt   = cfg_clamped;
      req_cnt_nxt = '0;
      pass_nxt    = '0;
      state_nxt   = wfac_pkg::ST_INIT;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfac_pkg::ST_INIT;
      pass_r      <= '0;
      req_cnt_r   <= '0;
      total_r     <= wfac_pkg::MAX_CELLS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      req_cnt_r   <= req_cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    full_r     <= full_nxt;
    best_v_r   <= best_v_nxt;
    best_lo_r  <= best_lo_nxt;
    best_hi_r  <= best_hi_nxt;
    pf_r       <= pf_nxt;
    nf_r       <= nf_nxt;
    plo_r      <= plo_nxt;
    nhi_r      <= nhi_nxt;
    blk_lo_r   <= blk_lo_nxt;
    blk_hi_r   <= blk_hi_nxt;
    placed_r   <= placed_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != wfac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
